// ===== sv/tpcb_pkg.sv =====
`default_nettype none
package tpcb_pkg;

    // Geometry of the buffer.
    localparam int MAX_ENTRIES = 16;
    localparam int COUNT_BITS  = 16;
    localparam int KEY_W       = 32;
    localparam int SIZE_W      = 5;
    localparam int CALL_W      = 16;
    localparam int CFG_W       = 16;

    // Occupancy runs 0..MAX_ENTRIES; before eviction it may reach MAX_ENTRIES+1.
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int PRE_W = $clog2(MAX_ENTRIES + 2);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef logic [KEY_W-1:0]      t_key;
    typedef logic [COUNT_BITS-1:0] t_count;

    // Register indexes on the configuration port.
    typedef enum logic {
        CFG_MAX_SIZE = 1'b0,
        CFG_MAX_CALL = 1'b1
    } t_cfg_idx;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic   step;     // an access word is accepted this cycle
        logic   miss;     // key not found in any valid cell
        logic   promote;  // hit count exceeds the promotion threshold
        t_key   key;      // key of the access
        t_count cnt;      // count of the accessed entry after the update
    } t_bcast;

    // Data handed from one cell to the next one toward the tail.
    typedef struct packed {
        t_key   key;
        t_count count;
        logic   found;    // a match was seen at or ahead of this point
    } t_link;

endpackage
`default_nettype wire

// ===== sv/threshold_promotion_cache_buffer_core.sv =====
`default_nettype none
// Ordered key buffer with saturating hit counts, built as a row of cells from head to
// tail. Each access word is looked up in all valid cells at once; a hit bumps the count
// and, above max_call, moves the entry to the head, while a miss inserts the key at the
// head with count one and the tail is evicted once occupancy passes max_size. One word
// is accepted per cycle while o_stall is low; its result appears in the output
// register on the next cycle; the cycle is set by the key compare across the cells and
// the shift of the row. The buffer is empty after reset and needs no clearing pass.
module threshold_promotion_cache_buffer_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [tpcb_pkg::KEY_W-1:0]     i_access_key,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_hit,
    output logic [tpcb_pkg::COUNT_BITS-1:0]     o_hit_count,
    output logic                                o_promoted,
    output logic                                o_evicted,
    output logic [tpcb_pkg::KEY_W-1:0]          o_evicted_key,
    output logic [tpcb_pkg::OCC_W-1:0]          o_occupancy,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_idx,
    input  wire logic [tpcb_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int N = tpcb_pkg::MAX_ENTRIES;

    logic [tpcb_pkg::SIZE_W-1:0] r_max_size;
    logic [tpcb_pkg::CALL_W-1:0] r_max_call;
    logic [tpcb_pkg::OCC_W-1:0]  r_occ;
    logic [tpcb_pkg::OCC_W-1:0]  n_occ;

    tpcb_pkg::t_bcast bcast;
    tpcb_pkg::t_link  links [N+1];
    tpcb_pkg::t_key   next_keys [N];
    tpcb_pkg::t_count sel_counts [N];

    logic                        accept;
    logic                        hit;
    tpcb_pkg::t_count            sel;
    tpcb_pkg::t_count            inc;
    tpcb_pkg::t_count            cnt;
    logic                        promote;
    logic [tpcb_pkg::PRE_W-1:0]  occ_pre;
    logic [tpcb_pkg::PRE_W-1:0]  lim;
    logic [tpcb_pkg::PRE_W-1:0]  ev_idx;
    logic                        evict;
    tpcb_pkg::t_key              ev_key;

    // Handshake: stall only while a finished word waits downstream.
    assign o_stall = o_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // The new head entry enters the row through the first link.
    assign links[0].key   = i_access_key;
    assign links[0].count = cnt;
    assign links[0].found = 1'b0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        tpcb_cell u_cell (
            .i_clk       (i_clk),
            .i_bcast     (bcast),
            .i_prev      (links[g]),
            .i_ent_valid (tpcb_pkg::OCC_W'(g) < r_occ),
            .o_link      (links[g+1]),
            .o_next_key  (next_keys[g]),
            .o_sel_count (sel_counts[g])
        );
    end

    // Count of the matched cell; at most one cell drives a nonzero value.
    always_comb begin
        sel = '0;
        for (int k = 0; k < N; k++) begin
            sel = sel | sel_counts[k];
        end
    end

    assign hit     = links[N].found;
    assign inc     = (sel == '1) ? sel : sel + tpcb_pkg::COUNT_BITS'(1);
    assign cnt     = hit ? inc : tpcb_pkg::COUNT_BITS'(1);
    assign promote = hit && (32'(inc) > 32'(r_max_call));

    assign bcast.step    = accept;
    assign bcast.miss    = !hit;
    assign bcast.promote = promote;
    assign bcast.key     = i_access_key;
    assign bcast.cnt     = cnt;

    // Occupancy and eviction; a size limit above capacity acts as capacity.
    assign occ_pre = tpcb_pkg::PRE_W'(r_occ) + tpcb_pkg::PRE_W'(!hit);
    assign lim     = (32'(r_max_size) > 32'(N)) ? tpcb_pkg::PRE_W'(N)
                                                : tpcb_pkg::PRE_W'(r_max_size);
    assign evict   = occ_pre > lim;
    assign n_occ   = tpcb_pkg::OCC_W'(occ_pre - tpcb_pkg::PRE_W'(evict));
    assign ev_idx  = occ_pre - tpcb_pkg::PRE_W'(1);

    // The tail after the update; one past the last cell is the word shifted out.
    always_comb begin
        if (ev_idx == tpcb_pkg::PRE_W'(N)) begin
            ev_key = links[N].key;
        end else begin
            ev_key = next_keys[ev_idx[tpcb_pkg::IDX_W-1:0]];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= tpcb_pkg::SIZE_W'(16);
            r_max_call <= tpcb_pkg::CALL_W'(3);
        end else if (i_cfg_we) begin
            unique case (tpcb_pkg::t_cfg_idx'(i_cfg_idx))
                tpcb_pkg::CFG_MAX_SIZE: r_max_size <= i_cfg_data[tpcb_pkg::SIZE_W-1:0];
                tpcb_pkg::CFG_MAX_CALL: r_max_call <= i_cfg_data[tpcb_pkg::CALL_W-1:0];
                default: ;
            endcase
        end
    end

    // Occupancy count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_occ   <= n_occ;
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_hit         <= hit;
            o_hit_count   <= cnt;
            o_promoted    <= promote;
            o_evicted     <= evict;
            o_evicted_key <= evict ? ev_key : '0;
            o_occupancy   <= n_occ;
        end
    end

    // Occupancy never passes the row length.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ) <= N)
        else $error("occupancy exceeds capacity");

    // Every accepted word leaves a result in the output register.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted word produced no result");

    // A promotion can only come from a hit.
    a_promote_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_promoted |-> o_hit)
        else $error("promotion without hit");

    // A miss always grows occupancy or evicts.
    a_miss_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !hit && !evict |=> r_occ == $past(r_occ) + tpcb_pkg::OCC_W'(1))
        else $error("miss lost an entry");

endmodule
`default_nettype wire

// ===== sv/tpcb_cell.sv =====
`default_nettype none
module tpcb_cell (
    input  wire logic            i_clk,
    input  wire tpcb_pkg::t_bcast i_bcast,
    input  wire tpcb_pkg::t_link  i_prev,
    input  wire logic            i_ent_valid,
    output tpcb_pkg::t_link       o_link,
    output tpcb_pkg::t_key        o_next_key,
    output tpcb_pkg::t_count      o_sel_count
);

    tpcb_pkg::t_key   r_key;
    tpcb_pkg::t_count r_count;
    tpcb_pkg::t_key   n_key;
    tpcb_pkg::t_count n_count;
    logic             match;
    logic             first;
    logic             shift;

    // Compare against the access key; only the first match in the chain counts.
    assign match = i_ent_valid && (r_key == i_bcast.key);
    assign first = match && !i_prev.found;

    // Cells at or ahead of the hit entry move back on a promotion; all move on a miss.
    assign shift = i_bcast.miss || (i_bcast.promote && !i_prev.found);

    always_comb begin
        n_key   = r_key;
        n_count = r_count;
        if (shift) begin
            n_key   = i_prev.key;
            n_count = i_prev.count;
        end else if (first) begin
            n_count = i_bcast.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bcast.step) begin
            r_key   <= n_key;
            r_count <= n_count;
        end
    end

    assign o_link.key   = r_key;
    assign o_link.count = r_count;
    assign o_link.found = i_prev.found || match;
    assign o_next_key   = n_key;
    assign o_sel_count  = first ? r_count : '0;

endmodule
`default_nettype wire

// ===== dv/tb_threshold_promotion_cache_buffer_core.sv =====
`timescale 1ns / 100ps
module tb_threshold_promotion_cache_buffer_core;

    // One result word as seen on the output side.
    typedef struct packed {
        logic                       hit;
        tpcb_pkg::t_count           count;
        logic                       promoted;
        logic                       evicted;
        tpcb_pkg::t_key             ev_key;
        logic [tpcb_pkg::OCC_W-1:0] occ;
    } t_access_outcome;

    logic                            i_clk;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    tpcb_pkg::t_key                  i_access_key = '0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic                            o_hit;
    tpcb_pkg::t_count                o_hit_count;
    logic                            o_promoted;
    logic                            o_evicted;
    tpcb_pkg::t_key                  o_evicted_key;
    logic [tpcb_pkg::OCC_W-1:0]      o_occupancy;
    logic                            i_cfg_we = 1'b0;
    logic                            i_cfg_idx = tpcb_pkg::CFG_MAX_SIZE;
    logic [tpcb_pkg::CFG_W-1:0]      i_cfg_data = '0;

    // Shadow copy of the buffer and its registers.
    tpcb_pkg::t_key                  line_key [tpcb_pkg::MAX_ENTRIES+1];
    tpcb_pkg::t_count                line_count [tpcb_pkg::MAX_ENTRIES+1];
    int unsigned                     used_lines = 0;
    logic [tpcb_pkg::SIZE_W-1:0]     size_limit = 5'd16;
    logic [tpcb_pkg::CALL_W-1:0]     promote_above = 16'd3;

    tpcb_pkg::t_key                  key_backlog [$];
    t_access_outcome                 due_outcomes [$];
    int                              bad_words = 0;
    int                              send_idle_pct = 0;
    int                              stall_pct = 0;

    threshold_promotion_cache_buffer_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_access_key (i_access_key),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hit        (o_hit),
        .o_hit_count  (o_hit_count),
        .o_promoted   (o_promoted),
        .o_evicted    (o_evicted),
        .o_evicted_key(o_evicted_key),
        .o_occupancy  (o_occupancy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Look up one key in the shadow buffer, update it and return the result word.
    function automatic t_access_outcome apply_access(input tpcb_pkg::t_key key);
        int unsigned      limit;
        int unsigned      fill;
        int unsigned      pos;
        bit               found;
        tpcb_pkg::t_count cnt;
        t_access_outcome  res;
        limit = (size_limit > tpcb_pkg::MAX_ENTRIES) ? tpcb_pkg::MAX_ENTRIES : size_limit;
        fill  = used_lines;
        pos   = 0;
        found = 1'b0;
        res   = '0;
        while (!found && pos < fill) begin
            if (line_key[pos] == key) found = 1'b1;
            else pos++;
        end
        if (found) begin
            if (line_count[pos] != '1) line_count[pos]++;
            cnt = line_count[pos];
            // A count above the threshold moves the entry to the head.
            if (cnt > promote_above) begin
                res.promoted = 1'b1;
                for (int j = pos; j > 0; j--) begin
                    line_key[j]   = line_key[j-1];
                    line_count[j] = line_count[j-1];
                end
                line_key[0]   = key;
                line_count[0] = cnt;
            end
        end else begin
            for (int j = fill; j > 0; j--) begin
                line_key[j]   = line_key[j-1];
                line_count[j] = line_count[j-1];
            end
            line_key[0]   = key;
            line_count[0] = 1;
            cnt           = 1;
            fill++;
        end
        // At most one tail entry leaves per access, hits included.
        if (fill > limit) begin
            res.evicted = 1'b1;
            res.ev_key  = line_key[fill-1];
            fill--;
        end
        used_lines = fill;
        res.hit    = found;
        res.count  = cnt;
        res.occ    = tpcb_pkg::OCC_W'(fill);
        return res;
    endfunction

    // Sender: presents backlog words, holds a stalled word, and predicts on acceptance.
    always @(posedge i_clk) begin
        bit hold;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                due_outcomes.push_back(apply_access(i_access_key));
                hold = 1'b0;
            end else begin
                hold = i_valid;
            end
            if (!hold) begin
                if (key_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_access_key <= key_backlog.pop_front();
                    i_valid      <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result word against the oldest prediction.
    always @(posedge i_clk) begin
        t_access_outcome got;
        t_access_outcome want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_hit, o_hit_count, o_promoted, o_evicted, o_evicted_key, o_occupancy};
                if (due_outcomes.size() == 0) begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("%0t: result word with none predicted: hit=%0b count=%0d",
                                 $realtime, got.hit, got.count);
                end else begin
                    want = due_outcomes.pop_front();
                    if (got !== want) begin
                        bad_words++;
                        if (bad_words <= 10) begin
                            $display("%0t: mismatch hit %0b/%0b count %0d/%0d promoted %0b/%0b",
                                     $realtime, want.hit, got.hit, want.count, got.count,
                                     want.promoted, got.promoted);
                            $display("    evicted %0b/%0b key %h/%h occupancy %0d/%0d",
                                     want.evicted, got.evicted, want.ev_key, got.ev_key,
                                     want.occ, got.occ);
                        end
                    end
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic queue_access(input tpcb_pkg::t_key key);
        key_backlog.push_back(key);
    endtask

    // Wait until every word has been accepted and every result has come back.
    task automatic wait_idle();
        while (key_backlog.size() != 0 || i_valid || due_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_reg(input tpcb_pkg::t_cfg_idx idx,
                             input logic [tpcb_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == tpcb_pkg::CFG_MAX_SIZE) size_limit = data[tpcb_pkg::SIZE_W-1:0];
        else promote_above = data[tpcb_pkg::CALL_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int             send_mix [4];
        int             stall_mix [4];
        tpcb_pkg::t_key pool [32];
        int             pool_n;
        int             pick;
        send_mix  = '{0, 80, 0, 14};
        stall_mix = '{0, 0, 80, 14};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under light idling on both sides.
        send_idle_pct = 14;
        stall_pct     = 14;
        // Key extremes; repeated hits end in a promotion from behind, then one at the head.
        queue_access(32'h0000_0000);
        queue_access(32'hFFFF_FFFF);
        repeat (4) queue_access(32'h0000_0000);
        queue_access(32'h5A5A_0001);
        wait_idle();
        // A hit on the tail that is not promoted evicts the hit entry itself.
        write_reg(tpcb_pkg::CFG_MAX_SIZE, 16'd2);
        queue_access(32'hFFFF_FFFF);
        wait_idle();
        // A zero size limit evicts on every access and drains the buffer.
        write_reg(tpcb_pkg::CFG_MAX_SIZE, 16'd0);
        queue_access(32'h0B0B_0B0B);
        queue_access(32'h5A5A_0001);
        queue_access(32'h0C0C_0C0C);
        queue_access(32'h0C0C_0C0C);
        queue_access(32'h0D0D_0D0D);
        wait_idle();
        // A limit above capacity acts as full capacity; fill past it.
        write_reg(tpcb_pkg::CFG_MAX_SIZE, 16'd31);
        write_reg(tpcb_pkg::CFG_MAX_CALL, 16'd1);
        for (int i = 0; i < tpcb_pkg::MAX_ENTRIES + 1; i++)
            queue_access(32'h1000_0000 + i * 32'h0101_0101);
        queue_access(32'h1000_0000 + 10 * 32'h0101_0101);
        wait_idle();
        // A limit lowered below occupancy trims one entry per access.
        write_reg(tpcb_pkg::CFG_MAX_SIZE, 16'd4);
        queue_access(32'h2222_0001);
        queue_access(32'h2222_0002);
        wait_idle();

        // A run of hits on one key at a threshold of 65534 climbs without a promotion.
        send_idle_pct = 0;
        stall_pct     = 0;
        write_reg(tpcb_pkg::CFG_MAX_CALL, 16'd65534);
        repeat (24) queue_access(32'hC0FF_EE00);
        wait_idle();

        // Random part: mostly reuse of a small key pool, so hits, promotions
        // and evictions are frequent; fresh keys are mixed in as noise.
        for (int mode = 0; mode < 4; mode++) begin
            send_idle_pct = send_mix[mode];
            stall_pct     = stall_mix[mode];
            for (int sub = 0; sub < 2; sub++) begin
                pick = $urandom_range(9);
                case (pick)
                    0:       write_reg(tpcb_pkg::CFG_MAX_SIZE, 16'd0);
                    1:       write_reg(tpcb_pkg::CFG_MAX_SIZE, 16'd1);
                    2:       write_reg(tpcb_pkg::CFG_MAX_SIZE, 16'd16);
                    3:       write_reg(tpcb_pkg::CFG_MAX_SIZE, 16'd31);
                    default: write_reg(tpcb_pkg::CFG_MAX_SIZE, 16'($urandom_range(16, 1)));
                endcase
                pick = $urandom_range(9);
                case (pick)
                    0:       write_reg(tpcb_pkg::CFG_MAX_CALL, 16'd0);
                    1:       write_reg(tpcb_pkg::CFG_MAX_CALL, 16'd65534);
                    2:       write_reg(tpcb_pkg::CFG_MAX_CALL, 16'd65535);
                    default: write_reg(tpcb_pkg::CFG_MAX_CALL, 16'($urandom_range(5, 1)));
                endcase
                pool_n = $urandom_range(24, 3);
                for (int i = 0; i < pool_n; i++)
                    pool[i] = $urandom;
                for (int n = 0; n < 75; n++) begin
                    if ($urandom_range(99) < 85)
                        queue_access(pool[$urandom_range(pool_n - 1)]);
                    else
                        queue_access($urandom);
                end
                wait_idle();
            end
        end

        repeat (10) @(posedge i_clk);
        if (bad_words == 0 && due_outcomes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard stop in case the block stops answering.
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tpcb_pkg.sv
sv/tpcb_cell.sv
sv/threshold_promotion_cache_buffer_core.sv
dv/tb_threshold_promotion_cache_buffer_core.sv
